// ===== design/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and codes for the frustum cull tester.
// ----------------------------------------------------------------------------
package fct_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_POINT  = 2'd1,
		FUNC_SPHERE = 2'd2,
		FUNC_BOX    = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		VERDICT_INSIDE    = 2'd0,
		VERDICT_INTERSECT = 2'd1,
		VERDICT_OUTSIDE   = 2'd2
	} verdict_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_FLUSH,
		ST_FINISH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;   // take the input word
		logic issue;     // feed one plane into the pipeline
		logic load_out;  // write the verdict into the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic pipe_empty;
		logic out_free;
	} stat_t;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int DIST_BITS = PROD_BITS + 2;

endpackage

// ===== design/fct_item_if.sv =====
// ----------------------------------------------------------------------------
// fct_item_if
// Input channel: one load or test word per handshake.
// ----------------------------------------------------------------------------
interface fct_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [2:0]  plane_index;
	logic [31:0] ax;
	logic [31:0] ay;
	logic [31:0] az;
	logic [31:0] bx;
	logic [31:0] by;
	logic [31:0] bz;

	modport source (
		output valid, func, plane_index, ax, ay, az, bx, by, bz,
		input  ready
	);
	modport sink (
		input  valid, func, plane_index, ax, ay, az, bx, by, bz,
		output ready
	);
endinterface

// ===== design/fct_result_if.sv =====
// ----------------------------------------------------------------------------
// fct_result_if
// Output channel: one verdict word per handshake.
// ----------------------------------------------------------------------------
interface fct_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (
		output valid, verdict,
		input  ready
	);
	modport sink (
		input  valid, verdict,
		output ready
	);
endinterface

// ===== design/fct_ctrl.sv =====
// ----------------------------------------------------------------------------
// fct_ctrl
// Sequencer: takes a word; for a test walks the planes through the pipeline
// and waits for it to drain; hands each verdict to the output register.
// ----------------------------------------------------------------------------
module fct_ctrl #(
	parameter int NUM_PLANES = 6,
	parameter int PIDX_W     = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic [1:0]        item_func,
	output logic              item_ready,
	output fct_pkg::cmd_t     cmd,
	output logic [PIDX_W-1:0] plane_sel,
	input  fct_pkg::stat_t    stat
);
	import fct_pkg::*;

	localparam logic [PIDX_W-1:0] LAST_PLANE = PIDX_W'(NUM_PLANES - 1);

	state_t            state_q, state_d;
	logic [PIDX_W-1:0] plane_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE)
				plane_q <= '0;
			else if (state_q == ST_ISSUE)
				plane_q <= plane_q + 1'b1;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (func_t'(item_func) == FUNC_LOAD)
						state_d = ST_FINISH;
					else
						state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (plane_q == LAST_PLANE)
					state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (stat.pipe_empty)
					state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready   = 1'b0;
		cmd.capture  = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready  = 1'b1;
				cmd.capture = item_valid;
			end
			ST_ISSUE:  cmd.issue = 1'b1;
			ST_FLUSH:  ;
			ST_FINISH: cmd.load_out = stat.out_free;
			default:   ;
		endcase
	end

	assign plane_sel = plane_q;

endmodule

// ===== design/fct_dp.sv =====
// ----------------------------------------------------------------------------
// fct_dp
// Plane store, three-stage distance pipeline (products, pair sums, corner
// sums), verdict flags and the output register.
// ----------------------------------------------------------------------------
module fct_dp #(
	parameter int NUM_PLANES = 6,
	parameter int COORD_BITS = 32,
	parameter int PIDX_W     = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	fct_item_if.sink          item,
	fct_result_if.source      result,
	input  fct_pkg::cmd_t     cmd,
	input  logic [PIDX_W-1:0] plane_sel,
	output fct_pkg::stat_t    stat
);
	import fct_pkg::*;

	localparam int SH = WORD_BITS - COORD_BITS;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
		logic signed [WORD_BITS-1:0] c;
		logic signed [WORD_BITS-1:0] d;
	} plane_t;

	function automatic logic signed [WORD_BITS-1:0] sext(input logic [WORD_BITS-1:0] v);
		logic signed [WORD_BITS-1:0] t;
		t = v << SH;
		return t >>> SH;
	endfunction

	plane_t plane_q [NUM_PLANES];

	func_t                       func_q;
	logic signed [WORD_BITS-1:0] lo_q [3];
	logic signed [WORD_BITS-1:0] hi_q [3];

	logic signed [PROD_BITS-1:0] px_s1 [2];
	logic signed [PROD_BITS-1:0] py_s1 [2];
	logic signed [PROD_BITS-1:0] pz_s1 [2];
	logic signed [WORD_BITS-1:0] d_s1;
	logic                        v_s1;

	logic signed [PROD_BITS:0]   xy_s2 [4];
	logic signed [PROD_BITS:0]   zd_s2 [2];
	logic                        v_s2;

	logic signed [DIST_BITS-1:0] dist_s3 [8];
	logic                        v_s3;

	logic out_q, isect_q, decided_q;
	logic res_valid_q;
	logic [1:0] res_verdict_q;

	plane_t                                  pl;
	logic signed [WORD_BITS+FRAC_BITS:0]     rpos, rneg;
	logic signed [WORD_BITS+FRAC_BITS-1:0]   dsh;
	logic [7:0]                              neg;
	logic                                    all_out, any_out;
	verdict_t                                verdict;
	logic                                    load_ok;

	assign load_ok = (32'(item.plane_index) < NUM_PLANES);

	// plane store and the word under test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLANES; i++)
				plane_q[i] <= '0;
		end else if (cmd.capture && func_t'(item.func) == FUNC_LOAD && load_ok) begin
			plane_q[PIDX_W'(item.plane_index)] <= '{a: sext(item.ax), b: sext(item.ay),
				c: sext(item.az), d: sext(item.bx)};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func_t'(item.func);
			lo_q[0] <= sext(item.ax);
			lo_q[1] <= sext(item.ay);
			lo_q[2] <= sext(item.az);
			hi_q[0] <= sext(item.bx);
			hi_q[1] <= sext(item.by);
			hi_q[2] <= sext(item.bz);
		end
	end

	assign pl  = plane_q[plane_sel];
	assign dsh = {d_s1, {FRAC_BITS{1'b0}}};

	// stage 1: six products, min and max of each axis
	always_ff @(posedge clk) begin
		px_s1[0] <= pl.a * lo_q[0];
		px_s1[1] <= pl.a * hi_q[0];
		py_s1[0] <= pl.b * lo_q[1];
		py_s1[1] <= pl.b * hi_q[1];
		pz_s1[0] <= pl.c * lo_q[2];
		pz_s1[1] <= pl.c * hi_q[2];
		d_s1     <= pl.d;
	end

	// stage 2: x+y for the four xy corners, z+d for the two z faces
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			for (int j = 0; j < 2; j++)
				xy_s2[2*i+j] <= (PROD_BITS+1)'(px_s1[i]) + (PROD_BITS+1)'(py_s1[j]);
			zd_s2[i] <= (PROD_BITS+1)'(pz_s1[i]) + (PROD_BITS+1)'(dsh);
		end
	end

	// stage 3: corner c = {x sel, y sel, z sel}; corner 0 is the point itself
	always_ff @(posedge clk) begin
		for (int c = 0; c < 8; c++)
			dist_s3[c] <= DIST_BITS'(xy_s2[c>>1]) + DIST_BITS'(zd_s2[c&1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign rpos = {hi_q[0][WORD_BITS-1], hi_q[0], {FRAC_BITS{1'b0}}};
	assign rneg = -rpos;

	always_comb begin
		for (int c = 0; c < 8; c++)
			neg[c] = dist_s3[c][DIST_BITS-1];
	end
	assign all_out = &neg;
	assign any_out = |neg;

	// plane outcomes do not depend on order except for the sphere's first decision
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q     <= 1'b0;
			isect_q   <= 1'b0;
			decided_q <= 1'b0;
		end else if (cmd.capture) begin
			out_q     <= 1'b0;
			isect_q   <= 1'b0;
			decided_q <= 1'b0;
		end else if (v_s3) begin
			case (func_q)
				FUNC_POINT: begin
					if (dist_s3[0] <= 0)
						out_q <= 1'b1;
				end
				FUNC_SPHERE: begin
					if (!decided_q) begin
						if (dist_s3[0] < rneg) begin
							out_q     <= 1'b1;
							decided_q <= 1'b1;
						end else if (!(dist_s3[0] > rpos)) begin
							isect_q   <= 1'b1;
							decided_q <= 1'b1;
						end
					end
				end
				FUNC_BOX: begin
					if (all_out)
						out_q <= 1'b1;
					else if (any_out)
						isect_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		if (out_q)
			verdict = VERDICT_OUTSIDE;
		else if (isect_q)
			verdict = VERDICT_INTERSECT;
		else
			verdict = VERDICT_INSIDE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.load_out)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out)
			res_verdict_q <= verdict;
	end

	assign result.valid   = res_valid_q;
	assign result.verdict = res_verdict_q;

	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3);
	assign stat.out_free   = !res_valid_q || result.ready;

endmodule

// ===== design/frustum_cull_tester.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_tester
// Six-plane view frustum test of points, spheres and boxes in Q16.16.
// ----------------------------------------------------------------------------
// A plane load answers verdict 0 as soon as the output register is free.
// A test walks the planes one per cycle through a three-stage pipeline that
// forms all eight box-corner distances of a plane at once (six 32x32
// multipliers, then pair sums, then corner sums); one word is in flight at
// a time. The input is ready again while the verdict still waits in the
// output register. Distances are exact in Q32.32; nothing saturates.
// Verdict: 0 inside, 1 intersect, 2 outside.
module frustum_cull_tester #(
	parameter int NUM_PLANES = 6,
	parameter int COORD_BITS = 32
) (
	input logic          clk,
	input logic          arst_n,
	fct_item_if.sink     item,
	fct_result_if.source result
);
	import fct_pkg::*;

	localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

	cmd_t              cmd;
	stat_t             stat;
	logic [PIDX_W-1:0] plane_sel;

	fct_ctrl #(
		.NUM_PLANES (NUM_PLANES),
		.PIDX_W     (PIDX_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_func  (item.func),
		.item_ready (item.ready),
		.cmd        (cmd),
		.plane_sel  (plane_sel),
		.stat       (stat)
	);

	fct_dp #(
		.NUM_PLANES (NUM_PLANES),
		.COORD_BITS (COORD_BITS),
		.PIDX_W     (PIDX_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cmd       (cmd),
		.plane_sel (plane_sel),
		.stat      (stat)
	);

endmodule

// ===== tb/sv/frustum_cull_tester_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frustum_cull_tester_tb
// Self-checking bench for the six-plane frustum cull tester. A queue-fed
// driver offers load and test words, a scoreboard computes each verdict from
// its own copy of the plane store at exact Q32.32 width, and a monitor checks
// every verdict word in order. It runs a short directed pass, then random
// phases with varying backpressure.
// ----------------------------------------------------------------------------
module frustum_cull_tester_tb;
	import fct_pkg::*;

	localparam int NUM_PLANES  = 6;
	localparam int COORD_BITS  = 32;
	localparam int ONE         = 65536;  // 1.0 in Q16.16
	localparam int PHASE_WORDS = 300;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		func_t              func;
		logic [2:0]         plane_index;
		logic signed [31:0] ax, ay, az, bx, by, bz;
	} cull_word_t;

	logic clk;
	logic arst_n;

	fct_item_if   item_ch ();
	fct_result_if result_ch ();

	frustum_cull_tester #(
		.NUM_PLANES(NUM_PLANES),
		.COORD_BITS(COORD_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	// scoreboard copy of the plane store: [plane][a, b, c, d]
	logic signed [31:0] plane_mem [0:NUM_PLANES-1][0:3];

	cull_word_t word_queue[$];
	verdict_t   verdict_q[$];
	cull_word_t drv_word;
	logic       item_taken;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         hold_req;
	int         hold_ack;
	int         hold_left;
	int         error_count;
	int         cycle_count;
	int         func_count [0:3];
	int         verdict_seen [0:3];

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// signed distance of (x, y, z) from plane p, exact in Q32.32
	function automatic logic signed [65:0] plane_dist(int p, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z);
		logic signed [65:0] a, b, c, d, xs, ys, zs;
		a  = plane_mem[p][0];
		b  = plane_mem[p][1];
		c  = plane_mem[p][2];
		d  = plane_mem[p][3];
		xs = x;
		ys = y;
		zs = z;
		return a * xs + b * ys + c * zs + (d <<< 16);
	endfunction

	function automatic verdict_t cull_predict(cull_word_t w);
		verdict_t           v;
		logic signed [65:0] sdist, rad;
		logic signed [31:0] cx, cy, cz;
		int                 nin;
		bit                 straddle, outside;
		v = VERDICT_INSIDE;
		case (w.func)
			FUNC_LOAD: begin
				if (w.plane_index < NUM_PLANES) begin
					plane_mem[w.plane_index][0] = w.ax;
					plane_mem[w.plane_index][1] = w.ay;
					plane_mem[w.plane_index][2] = w.az;
					plane_mem[w.plane_index][3] = w.bx;
				end
			end
			FUNC_POINT: begin
				for (int p = 0; p < NUM_PLANES; p++) begin
					if (plane_dist(p, w.ax, w.ay, w.az) <= 0) begin
						v = VERDICT_OUTSIDE;
						break;
					end
				end
			end
			FUNC_SPHERE: begin
				rad = w.bx;
				rad = rad <<< 16;
				// negative radius gets no special handling
				for (int p = 0; p < NUM_PLANES; p++) begin
					sdist = plane_dist(p, w.ax, w.ay, w.az);
					if (sdist < -rad) begin
						v = VERDICT_OUTSIDE;
						break;
					end
					if (sdist > rad)
						continue;
					v = VERDICT_INTERSECT;
					break;
				end
			end
			default: begin
				straddle = 1'b0;
				outside  = 1'b0;
				for (int p = 0; p < NUM_PLANES; p++) begin
					nin = 0;
					for (int c = 0; c < 8; c++) begin
						cx = (c & 4) ? w.bx : w.ax;
						cy = (c & 2) ? w.by : w.ay;
						cz = (c & 1) ? w.bz : w.az;
						if (plane_dist(p, cx, cy, cz) >= 0)
							nin++;
					end
					if (nin == 0) begin
						outside = 1'b1;
						break;
					end
					if (nin != 8)
						straddle = 1'b1;
				end
				v = outside ? VERDICT_OUTSIDE : (straddle ? VERDICT_INTERSECT : VERDICT_INSIDE);
			end
		endcase
		return v;
	endfunction

	function automatic cull_word_t mk_word(func_t f, logic [2:0] idx, logic signed [31:0] ax,
			logic signed [31:0] ay, logic signed [31:0] az, logic signed [31:0] bx,
			logic signed [31:0] by, logic signed [31:0] bz);
		cull_word_t w;
		w.func        = f;
		w.plane_index = idx;
		w.ax          = ax;
		w.ay          = ay;
		w.az          = az;
		w.bx          = bx;
		w.by          = by;
		w.bz          = bz;
		return w;
	endfunction

	// uniform in [-span, span], raw Q16.16
	function automatic logic signed [31:0] fx_rand(int span);
		int r;
		r = int'($urandom_range(2 * span)) - span;
		return r;
	endfunction

	function automatic cull_word_t gen_random_word();
		cull_word_t         w;
		logic signed [31:0] t;
		int                 roll;
		roll = $urandom_range(99);
		w = mk_word(func_t'($urandom_range(3)), 3'($urandom_range(7)), $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom);
		if (roll < 8)
			return w;  // raw noise across all bits
		if (roll < 20) begin
			// plane through a region around the origin; mostly valid slots
			w.func = FUNC_LOAD;
			w.plane_index = ($urandom_range(9) == 0) ? 3'($urandom_range(NUM_PLANES, 7))
				: 3'($urandom_range(NUM_PLANES - 1));
			w.ax = fx_rand(ONE);
			w.ay = fx_rand(ONE);
			w.az = fx_rand(ONE);
			w.bx = $urandom_range(32 * ONE);
			return w;
		end
		w.func = func_t'($urandom_range(1, 3));
		w.ax = fx_rand(24 * ONE);
		w.ay = fx_rand(24 * ONE);
		w.az = fx_rand(24 * ONE);
		if (w.func == FUNC_SPHERE) begin
			w.bx = $urandom_range(12 * ONE);
			if ($urandom_range(9) == 0)
				w.bx = -w.bx;
		end else if (w.func == FUNC_BOX) begin
			w.bx = w.ax + $urandom_range(16 * ONE);
			w.by = w.ay + $urandom_range(16 * ONE);
			w.bz = w.az + $urandom_range(16 * ONE);
			if ($urandom_range(9) == 0) begin
				t    = w.ax;
				w.ax = w.bx;
				w.bx = t;
			end
		end
		return w;
	endfunction

	task automatic fill_random(int n);
		for (int i = 0; i < n; i++)
			word_queue.push_back(gen_random_word());
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (word_queue.size() != 0 || item_ch.valid || verdict_q.size() != 0);
	endtask

	// driver: new word only once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!item_ch.valid || item_taken)) begin
			if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_word = word_queue.pop_front();
				item_ch.func        <= drv_word.func;
				item_ch.plane_index <= drv_word.plane_index;
				item_ch.ax          <= drv_word.ax;
				item_ch.ay          <= drv_word.ay;
				item_ch.az          <= drv_word.az;
				item_ch.bx          <= drv_word.bx;
				item_ch.by          <= drv_word.by;
				item_ch.bz          <= drv_word.bz;
				item_ch.valid       <= 1'b1;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		item_taken <= item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			verdict_q.push_back(cull_predict(drv_word));
			func_count[drv_word.func]++;
		end
	end

	always @(posedge clk) begin
		verdict_t exp_v;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			verdict_seen[result_ch.verdict]++;
			if (verdict_q.size() == 0) begin
				error_count++;
				$display("%0t: unexpected verdict word: expected none, got %0d",
					$time, result_ch.verdict);
			end else begin
				exp_v = verdict_q.pop_front();
				if (result_ch.verdict !== exp_v) begin
					error_count++;
					$display("%0t: verdict mismatch: expected %0d (%s), got %0d",
						$time, exp_v, exp_v.name(), result_ch.verdict);
				end
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d verdicts outstanding", cycle_count,
			verdict_q.size());
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.func        = FUNC_LOAD;
		item_ch.plane_index = '0;
		item_ch.ax          = '0;
		item_ch.ay          = '0;
		item_ch.az          = '0;
		item_ch.bx          = '0;
		item_ch.by          = '0;
		item_ch.bz          = '0;
		result_ch.ready     = 1'b0;
		item_taken          = 1'b0;
		send_idle_pct       = 0;
		recv_idle_pct       = 0;
		hold_req            = 0;
		hold_ack            = 0;
		hold_left           = 0;
		error_count         = 0;
		for (int i = 0; i < 4; i++) begin
			func_count[i]   = 0;
			verdict_seen[i] = 0;
		end
		for (int p = 0; p < NUM_PLANES; p++)
			for (int k = 0; k < 4; k++)
				plane_mem[p][k] = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// all-zero planes right after reset: every distance is zero
		word_queue.push_back(mk_word(FUNC_POINT, 0, 0, 0, 0, 0, 0, 0));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 0, 0, 0, 0, 0, 0));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 0, 0, 0, -ONE, 0, 0));
		word_queue.push_back(mk_word(FUNC_BOX, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
		// out-of-range slots leave the store alone
		word_queue.push_back(mk_word(FUNC_LOAD, 6, ONE, ONE, ONE, ONE, ONE, ONE));
		word_queue.push_back(mk_word(FUNC_LOAD, 7, -ONE, -ONE, -ONE, -ONE, -1, -1));
		// axis-aligned cube of half-width 8; junk in the unused fields
		word_queue.push_back(mk_word(FUNC_LOAD, 0, ONE, 0, 0, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_LOAD, 1, -ONE, 0, 0, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_LOAD, 2, 0, ONE, 0, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_LOAD, 3, 0, -ONE, 0, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_LOAD, 4, 0, 0, ONE, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_LOAD, 5, 0, 0, -ONE, 8 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_POINT, 0, 0, 0, 0, -1, -1, -1));
		word_queue.push_back(mk_word(FUNC_POINT, 0, 8 * ONE, 0, 0, 0, 0, 0));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 0, 0, 0, 2 * ONE, -1, -1));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 7 * ONE, 0, 0, 2 * ONE, 0, 0));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 11 * ONE, 0, 0, 2 * ONE, 0, 0));
		word_queue.push_back(mk_word(FUNC_BOX, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
		word_queue.push_back(mk_word(FUNC_BOX, 0, 6 * ONE, 0, 0, 10 * ONE, ONE, ONE));
		word_queue.push_back(mk_word(FUNC_BOX, 0, 9 * ONE, 0, 0, 12 * ONE, ONE, ONE));
		// min above max on every axis
		word_queue.push_back(mk_word(FUNC_BOX, 0, ONE, ONE, ONE, -ONE, -ONE, -ONE));
		// full-scale operands
		word_queue.push_back(mk_word(FUNC_POINT, 0, 32'h7FFFFFFF, 32'h80000000,
			32'h80000000, 0, 0, 0));
		word_queue.push_back(mk_word(FUNC_LOAD, 5, 32'h80000000, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 0, 0));
		word_queue.push_back(mk_word(FUNC_BOX, 0, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
		word_queue.push_back(mk_word(FUNC_SPHERE, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h7FFFFFFF, 0, 0));
		wait_drained();

		// sender mostly busy, receiver mostly stalled
		send_idle_pct = 6;
		recv_idle_pct = 87;
		fill_random(PHASE_WORDS);
		wait_drained();

		// sender mostly idle, receiver mostly ready
		send_idle_pct = 87;
		recv_idle_pct = 6;
		fill_random(PHASE_WORDS);
		wait_drained();

		// no idling, but open with a long receiver hold-off so the input backs up
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fill_random(PHASE_WORDS);
		hold_req++;
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d plane loads, %0d point, %0d sphere and %0d box tests",
			func_count[FUNC_LOAD], func_count[FUNC_POINT], func_count[FUNC_SPHERE],
			func_count[FUNC_BOX]);
		$display("Verdicts inside %0d, intersect %0d, outside %0d; %0d errors in %0d cycles",
			verdict_seen[VERDICT_INSIDE], verdict_seen[VERDICT_INTERSECT],
			verdict_seen[VERDICT_OUTSIDE], error_count, cycle_count);
		if (error_count == 0 && verdict_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
design/fct_pkg.sv
design/fct_item_if.sv
design/fct_result_if.sv
design/fct_ctrl.sv
design/fct_dp.sv
design/frustum_cull_tester.sv
tb/sv/frustum_cull_tester_tb.sv
